### sv/rcse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcse_pkg;

    localparam int STEP_W = 4;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TIMES = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [STEP_W-1:0] ENTRY_DIGIT = 4'd0;
    localparam logic [STEP_W-1:0] ENTRY_OPER  = 4'd1;
    localparam logic [STEP_W-1:0] ENTRY_EQ    = 4'd12;
    localparam logic [STEP_W-1:0] ENTRY_OTHER = 4'd15;

    typedef enum logic [3:0] {
        UOP_NOP        = 4'd0,
        UOP_PUSH_DIGIT = 4'd1,
        UOP_POP        = 4'd2,
        UOP_LOAD_R     = 4'd3,
        UOP_LOAD_L     = 4'd4,
        UOP_ARITH      = 4'd5,
        UOP_PUSH_RES   = 4'd6,
        UOP_DIV_START  = 4'd7,
        UOP_DIV_WAIT   = 4'd8,
        UOP_DIV_TAKE   = 4'd9,
        UOP_DIV_ZERO   = 4'd10,
        UOP_EMIT       = 4'd11,
        UOP_FINISH     = 4'd12
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_IS_DIV   = 3'd2,
        COND_R_ZERO   = 3'd3,
        COND_DIV_BUSY = 3'd4
    } cond_t;

    typedef struct packed {
        uop_t              op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ucw_t;

    typedef struct packed {
        logic is_div;
        logic r_zero;
        logic div_busy;
    } dp_stat_t;

    typedef struct packed {
        logic load_char;
        logic fire;
        uop_t op;
    } dp_ctrl_t;

    function automatic ucw_t ucode_word(input logic [STEP_W-1:0] step);
        ucw_t w;
        unique case (step)
            4'd0:    w = '{UOP_PUSH_DIGIT, COND_ALWAYS,   4'd15};
            4'd1:    w = '{UOP_POP,        COND_NEVER,    4'd0};
            4'd2:    w = '{UOP_LOAD_R,     COND_NEVER,    4'd0};
            4'd3:    w = '{UOP_POP,        COND_NEVER,    4'd0};
            4'd4:    w = '{UOP_LOAD_L,     COND_IS_DIV,   4'd7};
            4'd5:    w = '{UOP_ARITH,      COND_NEVER,    4'd0};
            4'd6:    w = '{UOP_PUSH_RES,   COND_ALWAYS,   4'd15};
            4'd7:    w = '{UOP_NOP,        COND_R_ZERO,   4'd11};
            4'd8:    w = '{UOP_DIV_START,  COND_NEVER,    4'd0};
            4'd9:    w = '{UOP_DIV_WAIT,   COND_DIV_BUSY, 4'd9};
            4'd10:   w = '{UOP_DIV_TAKE,   COND_ALWAYS,   4'd6};
            4'd11:   w = '{UOP_DIV_ZERO,   COND_ALWAYS,   4'd6};
            4'd12:   w = '{UOP_POP,        COND_NEVER,    4'd0};
            4'd13:   w = '{UOP_EMIT,       COND_ALWAYS,   4'd15};
            default: w = '{UOP_FINISH,     COND_NEVER,    4'd0};
        endcase
        return w;
    endfunction

    function automatic logic [STEP_W-1:0] entry_step(input logic [7:0] ch);
        logic [STEP_W-1:0] e;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            e = ENTRY_DIGIT;
        end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_TIMES || ch == CH_DIV) begin
            e = ENTRY_OPER;
        end else if (ch == CH_EQ) begin
            e = ENTRY_EQ;
        end else begin
            e = ENTRY_OTHER;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

### sv/rpn_char_stack_evaluator_top.sv
// Per request: an ignored character just finishes, a digit is pushed, '=' pops and emits,
// + - * pop two words and push the result; / uses a 32-step divider unless R is zero.
// One request is in work at a time; the next is taken the cycle after the result
// is registered, while that result may still wait on the output.
// The divide loop in the microprogram is the slowest path.
// Synchronous active-low reset empties the stack and idles the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module rpn_char_stack_evaluator_top #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_char_code,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic              m_value_ready,
    output logic signed [31:0] m_value,
    output logic              m_overflow_seen,
    output logic              m_underflow_seen,
    output logic              m_divide_by_zero
);

    rcse_pkg::dp_ctrl_t ctrl;
    rcse_pkg::dp_stat_t stat;

    rcse_sequencer u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .stat        (stat),
        .ctrl        (ctrl)
    );

    rcse_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .char_code      (s_char_code),
        .stat           (stat),
        .value_ready    (m_value_ready),
        .value          (m_value),
        .overflow_seen  (m_overflow_seen),
        .underflow_seen (m_underflow_seen),
        .divide_by_zero (m_divide_by_zero)
    );

endmodule

`default_nettype wire

### sv/rcse_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module rcse_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [31:0]      quotient
);

    logic        busy_reg, busy_next;
    logic [4:0]  count_reg, count_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic        neg_reg, neg_next;
    logic [32:0] rem_shift;
    logic [32:0] diff;

    always_comb begin
        busy_next  = busy_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        neg_next   = neg_reg;
        rem_shift  = {rem_reg[31:0], quo_reg[31]};
        diff       = rem_shift - {1'b0, dsr_reg};
        if (start) begin
            busy_next  = 1'b1;
            count_next = 5'd31;
            rem_next   = '0;
            quo_next   = dividend[31] ? (32'd0 - dividend) : dividend;
            dsr_next   = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next   = dividend[31] ^ divisor[31];
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_next = diff;
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = rem_shift;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            count_next = count_reg - 5'd1;
            if (count_reg == 5'd0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        count_reg <= count_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dsr_reg   <= dsr_next;
        neg_reg   <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

`default_nettype wire

### sv/rcse_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rcse_datapath #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire rcse_pkg::dp_ctrl_t  ctrl,
    input  wire logic [7:0]          char_code,
    output rcse_pkg::dp_stat_t       stat,
    output logic                     value_ready,
    output logic signed [31:0]       value,
    output logic                     overflow_seen,
    output logic                     underflow_seen,
    output logic                     divide_by_zero
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

    logic [31:0] mem [STACK_DEPTH];

    logic [DW-1:0] depth_reg, depth_next;
    logic [7:0]    char_reg, char_next;
    logic [31:0]   r_reg, r_next;
    logic [31:0]   l_reg, l_next;
    logic [31:0]   res_reg, res_next;
    logic [31:0]   val_reg, val_next;
    logic          rdy_reg, rdy_next;
    logic          ovf_reg, ovf_next;
    logic          unf_reg, unf_next;
    logic          dz_reg, dz_next;
    logic          empty_reg, empty_next;
    logic [31:0]   rd_data_reg;

    logic          out_rdy_reg;
    logic [31:0]   out_val_reg;
    logic          out_ovf_reg;
    logic          out_unf_reg;
    logic          out_dz_reg;

    logic          we;
    logic [31:0]   wdata;
    logic          re;
    logic [DW-1:0] depth_dec;
    logic [31:0]   popped;
    logic [63:0]   product;
    logic          div_start;
    logic          div_busy;
    logic [31:0]   quotient;
    logic          full;

    rcse_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (l_reg),
        .divisor  (r_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign full      = (depth_reg == DW'(STACK_DEPTH));
    assign depth_dec = depth_reg - DW'(1);
    assign popped    = empty_reg ? 32'd0 : rd_data_reg;
    assign product   = l_reg * r_reg;

    always_comb begin
        depth_next = depth_reg;
        char_next  = char_reg;
        r_next     = r_reg;
        l_next     = l_reg;
        res_next   = res_reg;
        val_next   = val_reg;
        rdy_next   = rdy_reg;
        ovf_next   = ovf_reg;
        unf_next   = unf_reg;
        dz_next    = dz_reg;
        empty_next = empty_reg;
        we         = 1'b0;
        wdata      = res_reg;
        re         = 1'b0;
        div_start  = 1'b0;
        if (ctrl.load_char) begin
            char_next = char_code;
            val_next  = '0;
            rdy_next  = 1'b0;
            ovf_next  = 1'b0;
            unf_next  = 1'b0;
            dz_next   = 1'b0;
        end else if (ctrl.fire) begin
            unique case (ctrl.op)
                rcse_pkg::UOP_PUSH_DIGIT, rcse_pkg::UOP_PUSH_RES: begin
                    if (ctrl.op == rcse_pkg::UOP_PUSH_DIGIT) begin
                        wdata = {28'd0, char_reg[3:0]};
                    end
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        we         = 1'b1;
                        depth_next = depth_reg + DW'(1);
                    end
                end
                rcse_pkg::UOP_POP: begin
                    if (depth_reg == '0) begin
                        unf_next   = 1'b1;
                        empty_next = 1'b1;
                    end else begin
                        empty_next = 1'b0;
                        re         = 1'b1;
                        depth_next = depth_dec;
                    end
                end
                rcse_pkg::UOP_LOAD_R: r_next = popped;
                rcse_pkg::UOP_LOAD_L: l_next = popped;
                rcse_pkg::UOP_ARITH: begin
                    if (char_reg == rcse_pkg::CH_PLUS) begin
                        res_next = l_reg + r_reg;
                    end else if (char_reg == rcse_pkg::CH_MINUS) begin
                        res_next = l_reg - r_reg;
                    end else begin
                        res_next = product[31:0];
                    end
                end
                rcse_pkg::UOP_DIV_START: div_start = 1'b1;
                rcse_pkg::UOP_DIV_TAKE:  res_next  = quotient;
                rcse_pkg::UOP_DIV_ZERO: begin
                    res_next = '0;
                    dz_next  = 1'b1;
                end
                rcse_pkg::UOP_EMIT: begin
                    val_next   = popped;
                    rdy_next   = 1'b1;
                    depth_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[depth_reg[AW-1:0]] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem[depth_dec[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
        end else begin
            depth_reg <= depth_next;
        end
        char_reg  <= char_next;
        r_reg     <= r_next;
        l_reg     <= l_next;
        res_reg   <= res_next;
        val_reg   <= val_next;
        rdy_reg   <= rdy_next;
        ovf_reg   <= ovf_next;
        unf_reg   <= unf_next;
        dz_reg    <= dz_next;
        empty_reg <= empty_next;
        if (ctrl.fire && ctrl.op == rcse_pkg::UOP_FINISH) begin
            out_rdy_reg <= rdy_reg;
            out_val_reg <= val_reg;
            out_ovf_reg <= ovf_reg;
            out_unf_reg <= unf_reg;
            out_dz_reg  <= dz_reg;
        end
    end

    assign stat.is_div   = (char_reg == rcse_pkg::CH_DIV);
    assign stat.r_zero   = (r_reg == 32'd0);
    assign stat.div_busy = div_busy;

    assign value_ready    = out_rdy_reg;
    assign value          = out_val_reg;
    assign overflow_seen  = out_ovf_reg;
    assign underflow_seen = out_unf_reg;
    assign divide_by_zero = out_dz_reg;

endmodule

`default_nettype wire

### sv/rcse_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

module rcse_sequencer (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_char_code,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire rcse_pkg::dp_stat_t  stat,
    output rcse_pkg::dp_ctrl_t       ctrl
);

    logic [rcse_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        run_reg, run_next;
    logic                        mvalid_reg, mvalid_next;
    rcse_pkg::ucw_t              cw;
    logic                        accept;
    logic                        fire;
    logic                        taken;

    assign cw     = rcse_pkg::ucode_word(step_reg);
    assign accept = s_valid && !run_reg;
    assign fire   = run_reg && (cw.op != rcse_pkg::UOP_FINISH || !mvalid_reg || m_ready);

    always_comb begin
        unique case (cw.cond)
            rcse_pkg::COND_ALWAYS:   taken = 1'b1;
            rcse_pkg::COND_IS_DIV:   taken = stat.is_div;
            rcse_pkg::COND_R_ZERO:   taken = stat.r_zero;
            rcse_pkg::COND_DIV_BUSY: taken = stat.div_busy;
            default:                 taken = 1'b0;
        endcase
    end

    always_comb begin
        step_next   = step_reg;
        run_next    = run_reg;
        mvalid_next = mvalid_reg;
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        if (accept) begin
            step_next = rcse_pkg::entry_step(s_char_code);
            run_next  = 1'b1;
        end else if (fire) begin
            if (cw.op == rcse_pkg::UOP_FINISH) begin
                run_next    = 1'b0;
                mvalid_next = 1'b1;
            end else if (taken) begin
                step_next = cw.target;
            end else begin
                step_next = step_reg + rcse_pkg::STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= '0;
            run_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            step_reg   <= step_next;
            run_reg    <= run_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_ready        = !run_reg;
    assign m_valid        = mvalid_reg;
    assign ctrl.load_char = accept;
    assign ctrl.fire      = fire;
    assign ctrl.op        = cw.op;

endmodule

`default_nettype wire

### bench/tb_rpn_char_stack_evaluator_top.sv
`timescale 1ns / 1ps

module tb_rpn_char_stack_evaluator_top;

    localparam int DEPTH = 128;
    localparam int LIMIT = 800_000;
    localparam int HOLD_LEN = 300;
    localparam int PHASE_ITEMS = 330;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [7:0] CH_PLUS  = rcse_pkg::CH_PLUS;
    localparam logic [7:0] CH_MINUS = rcse_pkg::CH_MINUS;
    localparam logic [7:0] CH_TIMES = rcse_pkg::CH_TIMES;
    localparam logic [7:0] CH_DIV   = rcse_pkg::CH_DIV;
    localparam logic [7:0] CH_EQ    = rcse_pkg::CH_EQ;
    localparam logic [7:0] CH_ZERO  = rcse_pkg::CH_ZERO;
    localparam logic [7:0] CH_NINE  = rcse_pkg::CH_NINE;
    localparam logic [7:0] CH_QUIT = 8'h71;
    localparam logic [3:0][7:0] OPER_CHARS = {CH_DIV, CH_TIMES, CH_MINUS, CH_PLUS};

    typedef struct packed {
        logic        value_ready;
        logic [31:0] value;
        logic        overflow_seen;
        logic        underflow_seen;
        logic        divide_by_zero;
    } result_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        result_t    exp;
    } dir_row_t;

    typedef enum int {SEQ_EXPR, SEQ_CHAIN, SEQ_MINDIV, SEQ_BROKEN, SEQ_FILL} seq_kind_t;

    localparam result_t R_QUIET    = '0;
    localparam result_t R_EMPTY_EQ = '{1'b1, 32'd0, 1'b0, 1'b1, 1'b0};
    localparam result_t R_ZERO_EQ  = '{1'b1, 32'd0, 1'b0, 1'b0, 1'b0};
    localparam result_t R_UNDER    = '{1'b0, 32'd0, 1'b0, 1'b1, 1'b0};
    localparam result_t R_DZ       = '{1'b0, 32'd0, 1'b0, 1'b0, 1'b1};
    localparam result_t R_UNDER_DZ = '{1'b0, 32'd0, 1'b0, 1'b1, 1'b1};

    // Error cases on an empty stack first, then a short expression that uses every operator, then an underflow and '='.
    dir_row_t dir_rows [25] = '{
        '{CH_EQ,           1'b1, R_EMPTY_EQ},
        '{CH_QUIT,         1'b1, R_QUIET},
        '{8'h00,           1'b1, R_QUIET},
        '{8'hFF,           1'b1, R_QUIET},
        '{CH_PLUS,         1'b1, R_UNDER},
        '{CH_DIV,          1'b1, R_UNDER_DZ},
        '{CH_EQ,           1'b1, R_ZERO_EQ},
        '{CH_NINE,         1'b1, R_QUIET},
        '{CH_ZERO + 8'd7,  1'b1, R_QUIET},
        '{CH_MINUS,        1'b0, R_QUIET},
        '{CH_ZERO,         1'b1, R_QUIET},
        '{CH_DIV,          1'b1, R_DZ},
        '{CH_ZERO + 8'd6,  1'b1, R_QUIET},
        '{CH_TIMES,        1'b0, R_QUIET},
        '{CH_ZERO + 8'd8,  1'b1, R_QUIET},
        '{CH_PLUS,         1'b0, R_QUIET},
        '{CH_ZERO + 8'd3,  1'b1, R_QUIET},
        '{CH_DIV,          1'b0, R_QUIET},
        '{CH_ZERO + 8'd5,  1'b1, R_QUIET},
        '{CH_MINUS,        1'b0, R_QUIET},
        '{CH_ZERO + 8'd2,  1'b1, R_QUIET},
        '{CH_DIV,          1'b0, R_QUIET},
        '{CH_EQ,           1'b0, R_QUIET},
        '{CH_MINUS,        1'b1, R_UNDER},
        '{CH_EQ,           1'b1, R_ZERO_EQ}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_value_ready;
    logic signed [31:0] m_value;
    logic        m_overflow_seen;
    logic        m_underflow_seen;
    logic        m_divide_by_zero;

    logic        cur_typed = 1'b0;
    result_t     cur_exp = '0;
    result_t     answer_q [$];
    logic [31:0] stk [DEPTH];
    int          stk_count = 0;
    bit          under_hit = 1'b0;

    int errors = 0;
    int cycle_cnt = 0;
    int useful_sent = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    rpn_char_stack_evaluator_top #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value_ready   (m_value_ready),
        .m_value         (m_value),
        .m_overflow_seen (m_overflow_seen),
        .m_underflow_seen(m_underflow_seen),
        .m_divide_by_zero(m_divide_by_zero)
    );

    always #4 aclk = ~aclk;

    function automatic bit push_word(input logic [31:0] v);
        if (stk_count >= DEPTH) begin
            return 1'b1;
        end
        stk[stk_count] = v;
        stk_count = stk_count + 1;
        return 1'b0;
    endfunction

    function automatic logic [31:0] pop_word();
        if (stk_count == 0) begin
            under_hit = 1'b1;
            return 32'd0;
        end
        stk_count = stk_count - 1;
        return stk[stk_count];
    endfunction

    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    // Applies one character to the shadow stack and returns the result it should produce.
    function automatic result_t rpn_eval(input logic [7:0] c);
        result_t r;
        logic [31:0] lhs;
        logic [31:0] rhs;
        r = '0;
        under_hit = 1'b0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r.overflow_seen = push_word({24'd0, c - CH_ZERO});
        end else if (c == CH_PLUS || c == CH_MINUS || c == CH_TIMES || c == CH_DIV) begin
            rhs = pop_word();
            lhs = pop_word();
            case (c)
                CH_PLUS: begin
                    r.overflow_seen = push_word(lhs + rhs);
                end
                CH_MINUS: begin
                    r.overflow_seen = push_word(lhs - rhs);
                end
                CH_TIMES: begin
                    r.overflow_seen = push_word(lhs * rhs);
                end
                default: begin
                    if (rhs == 32'd0) begin
                        r.divide_by_zero = 1'b1;
                        r.overflow_seen = push_word(32'd0);
                    end else begin
                        r.overflow_seen = push_word(div_trunc(lhs, rhs));
                    end
                end
            endcase
        end else if (c == CH_EQ) begin
            r.value = pop_word();
            r.value_ready = 1'b1;
            stk_count = 0;
        end
        r.underflow_seen = under_hit;
        return r;
    endfunction

    task automatic report(input string what);
        if (errors < 40) begin
            $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
        end
        errors = errors + 1;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin : result_monitor
        result_t calc;
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                calc = rpn_eval(s_char_code);
                answer_q.push_back(cur_typed ? cur_exp : calc);
            end
            if (m_valid && m_ready) begin
                if (answer_q.size() == 0) begin
                    report("result arrived with no request outstanding");
                end else begin
                    want = answer_q.pop_front();
                    check_field("value_ready", 32'(m_value_ready), 32'(want.value_ready));
                    check_field("value", m_value, want.value);
                    check_field("overflow_seen", 32'(m_overflow_seen),
                                32'(want.overflow_seen));
                    check_field("underflow_seen", 32'(m_underflow_seen),
                                32'(want.underflow_seen));
                    check_field("divide_by_zero", 32'(m_divide_by_zero),
                                32'(want.divide_by_zero));
                end
            end
        end
    end

    // The receiver stalls at random, or for a long stretch whenever one is asked for.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            m_ready <= 1'b0;
            hold_seen <= hold_asks;
            hold_left <= HOLD_LEN;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic put_char(input logic [7:0] c, input logic typed = 1'b0,
                            input result_t exp = '0);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_char_code <= c;
        cur_typed <= typed;
        cur_exp <= exp;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
            c == CH_TIMES || c == CH_DIV || c == CH_EQ) begin
            useful_sent = useful_sent + 1;
        end
        @(negedge aclk);
    endtask

    task automatic send_sequence(input seq_kind_t kind);
        int operands;
        int pushed;
        int depth;
        int pick;
        case (kind)
            SEQ_EXPR: begin
                operands = $urandom_range(1, 8);
                pushed = 0;
                depth = 0;
                while (pushed < operands || depth > 1) begin
                    if ($urandom_range(0, 9) == 0) begin
                        put_char(8'($urandom_range(0, 255)));
                    end
                    if (pushed < operands && (depth < 2 || $urandom_range(0, 1) == 1)) begin
                        put_char(CH_ZERO + 8'($urandom_range(0, 9)));
                        pushed = pushed + 1;
                        depth = depth + 1;
                    end else begin
                        put_char(OPER_CHARS[2'($urandom_range(0, 3))]);
                        depth = depth - 1;
                    end
                end
                if ($urandom_range(0, 9) != 0) begin
                    put_char(CH_EQ);
                end
            end
            SEQ_CHAIN: begin
                put_char(CH_ZERO + 8'($urandom_range(1, 9)));
                repeat ($urandom_range(4, 14)) begin
                    put_char(CH_ZERO + 8'($urandom_range(0, 9)));
                    pick = $urandom_range(0, 9);
                    put_char(pick < 6 ? CH_TIMES : OPER_CHARS[2'($urandom_range(0, 3))]);
                end
                put_char(CH_EQ);
            end
            SEQ_MINDIV: begin
                // 2 * 8^10 wraps to the most negative word.
                put_char(CH_ZERO + 8'd2);
                repeat (10) begin
                    put_char(CH_ZERO + 8'd8);
                    put_char(CH_TIMES);
                end
                if ($urandom_range(0, 9) < 6) begin
                    put_char(CH_ZERO);
                    put_char(CH_ZERO + 8'd1);
                    put_char(CH_MINUS);
                end else begin
                    put_char(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                put_char(CH_DIV);
                put_char(CH_EQ);
            end
            SEQ_BROKEN: begin
                repeat ($urandom_range(1, 6)) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5) begin
                        put_char(OPER_CHARS[2'($urandom_range(0, 3))]);
                    end else if (pick < 7) begin
                        put_char(CH_EQ);
                    end else if (pick < 9) begin
                        put_char(CH_ZERO + 8'($urandom_range(0, 9)));
                    end else begin
                        put_char(8'($urandom_range(0, 255)));
                    end
                end
            end
            default: begin
                repeat (DEPTH + $urandom_range(1, 4)) begin
                    put_char(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                repeat ($urandom_range(1, 5)) begin
                    put_char(OPER_CHARS[2'($urandom_range(0, 3))]);
                end
                put_char(CH_EQ);
            end
        endcase
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (answer_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin : stimulus
        int target;
        int pick;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        send_idle = 18;
        recv_idle <= 75;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            put_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].exp);
        end
        wait_all_results();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 18 : (phase == 1) ? 75 : 0;
            recv_idle <= (phase == 0) ? 75 : (phase == 1) ? 18 : 0;
            if (phase == 2) begin
                hold_asks <= hold_asks + 1;
            end
            @(negedge aclk);
            if (phase < 2) begin
                send_sequence(SEQ_FILL);
            end
            target = useful_sent + PHASE_ITEMS;
            while (useful_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    send_sequence(SEQ_EXPR);
                end else if (pick < 80) begin
                    send_sequence(SEQ_CHAIN);
                end else if (pick < 86) begin
                    send_sequence(SEQ_MINDIV);
                end else begin
                    send_sequence(SEQ_BROKEN);
                end
            end
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/rcse_pkg.sv
sv/rcse_divider.sv
sv/rcse_datapath.sv
sv/rcse_sequencer.sv
sv/rpn_char_stack_evaluator_top.sv
bench/tb_rpn_char_stack_evaluator_top.sv
